// File: rtl/tslru_pkg.sv
// Shared types and constants for the thumbnail slot cache with LRU replacement.
// Used by tslru_cell and thumbnail_slot_cache_lru_core; no other dependencies.
package tslru_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int STAMP_W = 32;
    localparam int KEY_W   = 16;
    localparam int FRAME_W = 24;
    localparam int ACT_W   = 2;

    // Action codes carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_REQUEST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP   = 2'd2;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_PENDING = 2'd1,
        ST_READY   = 2'd2,
        ST_FAILED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WR_REFRESH,
        WR_INSTALL,
        WR_STATUS
    } wr_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    // Item under search, broadcast to every cell
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
    } query_t;

    // Token handed from cell to cell during a scan
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               vic_valid;
        logic [IDX_W-1:0]   vic_idx;
        logic [STAMP_W-1:0] vic_stamp;
    } scan_t;

    // Write command broadcast to the cells at the end of a scan
    typedef struct packed {
        logic               en;
        wr_op_t             op;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
        status_t            status;
        logic [STAMP_W-1:0] stamp;
    } wr_t;

endpackage

// File: rtl/thumbnail_slot_cache_lru_core.sv
// Top level of the thumbnail slot cache: controller, use clock and the chain
// of slot cells. Depends on tslru_pkg and tslru_cell.
//
// Usage:
//   Input stream (s_axis_*): one transfer per item. tuser carries the action
//   (request fetch, fetch completion, lookup); tdata carries media key, frame
//   number and the engine_accepts / fetch_ok flags.
//   Output stream (m_axis_*): one transfer per item with slot, found, issued.
//   Timing: after an item is accepted the scan token walks the row of ENTRIES
//   cells, one cell per cycle, then the update state writes the chosen slot
//   and loads the output register. The next item is taken only after the
//   update, so the block handles one item at a time and never overlaps them.
//   Stall: the finished result waits in the output register while the next
//   item is accepted and scanned; that item's update waits until the
//   previous result has been taken.
//   Reset: all slots empty with zero key, frame and stamp; use clock zero;
//   the block is ready for an item in the first cycle after reset.
module thumbnail_slot_cache_lru_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // media_key[15:0], frame_number[39:16],
                                       // engine_accepts[40], fetch_ok[41], zero pad
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // slot[4:0], found[5], issued[6], zero pad
);

    localparam int ENTRIES = tslru_pkg::ENTRIES;
    localparam int IDX_W   = tslru_pkg::IDX_W;
    localparam int STAMP_W = tslru_pkg::STAMP_W;

    tslru_pkg::state_t     state_reg, state_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    tslru_pkg::query_t     query_reg, query_next;
    logic                  accepts_reg, accepts_next;
    logic                  ok_reg, ok_next;
    logic [STAMP_W-1:0]    use_clock_reg, use_clock_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_slot_reg, out_slot_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_issued_reg, out_issued_next;

    logic                  in_fire;
    logic                  upd_fire;
    logic                  scan_done;
    tslru_pkg::scan_t      tail;
    tslru_pkg::wr_t        wr;
    logic [IDX_W-1:0]      res_slot;
    logic                  res_found;
    logic                  res_issued;
    logic                  bump_clock;
    logic [STAMP_W-1:0]    new_stamp;

    tslru_pkg::scan_t      chain [ENTRIES+1];

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign upd_fire  = (state_reg == tslru_pkg::S_UPDATE) && (!out_valid_reg || m_axis_tready);
    assign scan_done = (cnt_reg == IDX_W'(ENTRIES - 1));
    assign tail      = chain[ENTRIES];
    assign new_stamp = use_clock_reg + STAMP_W'(1);

    // Row of slot cells; the scan token enters at cell 0 empty
    assign chain[0] = '0;
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tslru_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (IDX_W'(g)),
            .query    (query_reg),
            .wr       (wr),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tslru_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = tslru_pkg::S_SCAN;
                end
            end
            tslru_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = tslru_pkg::S_UPDATE;
                end
            end
            tslru_pkg::S_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = tslru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tslru_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the controller: result and the slot write from the scan token
    always_comb
    begin
        s_axis_tready = (state_reg == tslru_pkg::S_IDLE);
        res_slot      = '0;
        res_found     = 1'b0;
        res_issued    = 1'b0;
        bump_clock    = 1'b0;
        wr            = '0;
        wr.op         = tslru_pkg::WR_REFRESH;
        wr.status     = tslru_pkg::ST_EMPTY;
        wr.key        = query_reg.key;
        wr.frame      = query_reg.frame;
        wr.stamp      = new_stamp;
        unique case (query_reg.action)
            tslru_pkg::ACT_REQUEST:
            begin
                if (tail.hit)
                begin
                    res_slot   = tail.hit_idx;
                    res_found  = 1'b1;
                    bump_clock = 1'b1;
                    wr.op      = tslru_pkg::WR_REFRESH;
                    wr.idx     = tail.hit_idx;
                end
                else if (tail.vic_valid && accepts_reg)
                begin
                    res_slot   = tail.vic_idx;
                    res_issued = 1'b1;
                    bump_clock = 1'b1;
                    wr.op      = tslru_pkg::WR_INSTALL;
                    wr.idx     = tail.vic_idx;
                end
            end
            tslru_pkg::ACT_COMPLETE:
            begin
                if (tail.hit)
                begin
                    res_slot  = tail.hit_idx;
                    res_found = 1'b1;
                    wr.op     = tslru_pkg::WR_STATUS;
                    wr.idx    = tail.hit_idx;
                    wr.status = ok_reg ? tslru_pkg::ST_READY : tslru_pkg::ST_FAILED;
                end
            end
            tslru_pkg::ACT_LOOKUP:
            begin
                if (tail.hit)
                begin
                    res_slot  = tail.hit_idx;
                    res_found = 1'b1;
                end
            end
            default:
            begin
                res_slot = '0;
            end
        endcase
        // Only requests that hit or install and completions that match write
        wr.en = upd_fire && (bump_clock ||
                (res_found && (query_reg.action == tslru_pkg::ACT_COMPLETE)));
    end

    // Datapath next values: query capture, scan counter, use clock, output register
    always_comb
    begin
        query_next      = query_reg;
        accepts_next    = accepts_reg;
        ok_next         = ok_reg;
        cnt_next        = cnt_reg;
        use_clock_next  = use_clock_reg;
        out_valid_next  = out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_found_next  = out_found_reg;
        out_issued_next = out_issued_reg;

        if (in_fire)
        begin
            query_next.action = s_axis_tuser;
            query_next.key    = s_axis_tdata[15:0];
            query_next.frame  = s_axis_tdata[39:16];
            accepts_next      = s_axis_tdata[40];
            ok_next           = s_axis_tdata[41];
            cnt_next          = '0;
        end
        else if (state_reg == tslru_pkg::S_SCAN)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end

        // Drop the result once taken; load the new one on update
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (upd_fire)
        begin
            out_valid_next  = 1'b1;
            out_slot_next   = res_slot;
            out_found_next  = res_found;
            out_issued_next = res_issued;
            if (bump_clock)
            begin
                use_clock_next = new_stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tslru_pkg::S_IDLE;
            cnt_reg       <= '0;
            use_clock_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            use_clock_reg <= use_clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        accepts_reg    <= accepts_next;
        ok_reg         <= ok_next;
        out_slot_reg   <= out_slot_next;
        out_found_reg  <= out_found_next;
        out_issued_reg <= out_issued_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_issued_reg, out_found_reg, out_slot_reg};

    // A result never reports both a hit and a new install
    a_found_issued_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_found_reg && out_issued_reg))
        else $error("found and issued both set");

    // Slot reads zero when nothing was hit or installed
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_found_reg && !out_issued_reg) |-> (out_slot_reg == '0))
        else $error("slot nonzero on empty result");

    // Accepted item always starts a scan from the first cell
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == tslru_pkg::S_SCAN) && (cnt_reg == '0))
        else $error("scan did not start after transfer");

    // Use clock moves only in the update cycle
    a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tslru_pkg::S_UPDATE) |=> $stable(use_clock_reg))
        else $error("use clock changed outside update");

endmodule

// File: rtl/tslru_cell.sv
// One slot of the thumbnail cache: key, frame, status and last-use stamp,
// plus one stage of the scan chain. Depends on tslru_pkg.
module tslru_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [tslru_pkg::IDX_W-1:0] index,
    input  tslru_pkg::query_t       query,
    input  tslru_pkg::wr_t          wr,
    input  tslru_pkg::scan_t        scan_in,
    output tslru_pkg::scan_t        scan_out
);

    logic [tslru_pkg::KEY_W-1:0]   key_reg,    key_next;
    logic [tslru_pkg::FRAME_W-1:0] frame_reg,  frame_next;
    tslru_pkg::status_t            status_reg, status_next;
    logic [tslru_pkg::STAMP_W-1:0] stamp_reg,  stamp_next;
    tslru_pkg::scan_t              scan_reg,   scan_next;
    logic                          key_eq;
    logic                          hit_here;
    logic                          better_victim;

    // Match this slot against the query; lookups need a ready slot
    always_comb
    begin
        key_eq = (key_reg == query.key) && (frame_reg == query.frame);
        if (query.action == tslru_pkg::ACT_LOOKUP)
        begin
            hit_here = key_eq && (status_reg == tslru_pkg::ST_READY);
        end
        else
        begin
            hit_here = key_eq && (status_reg != tslru_pkg::ST_EMPTY);
        end
        better_victim = (status_reg != tslru_pkg::ST_PENDING) &&
                        (!scan_in.vic_valid || (stamp_reg < scan_in.vic_stamp));
    end

    // Advance the scan token: keep the first hit; until then, track the oldest non-pending slot
    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit)
        begin
            if (hit_here)
            begin
                scan_next.hit     = 1'b1;
                scan_next.hit_idx = index;
            end
            if (better_victim)
            begin
                scan_next.vic_valid = 1'b1;
                scan_next.vic_idx   = index;
                scan_next.vic_stamp = stamp_reg;
            end
        end
    end

    // Apply a write command addressed to this slot
    always_comb
    begin
        key_next    = key_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        stamp_next  = stamp_reg;
        if (wr.en && (wr.idx == index))
        begin
            unique case (wr.op)
                tslru_pkg::WR_REFRESH:
                begin
                    stamp_next = wr.stamp;
                end
                tslru_pkg::WR_INSTALL:
                begin
                    key_next    = wr.key;
                    frame_next  = wr.frame;
                    status_next = tslru_pkg::ST_PENDING;
                    stamp_next  = wr.stamp;
                end
                tslru_pkg::WR_STATUS:
                begin
                    status_next = wr.status;
                end
                default:
                begin
                    stamp_next = stamp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            frame_reg  <= '0;
            status_reg <= tslru_pkg::ST_EMPTY;
            stamp_reg  <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            key_reg    <= key_next;
            frame_reg  <= frame_next;
            status_reg <= status_next;
            stamp_reg  <= stamp_next;
            scan_reg   <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule
